[src/chroma_sub_pkg.sv]
// ----------------------------------------------------------------------------
// chroma_sub_pkg
// shared codes and types for the chroma subsampler
// ----------------------------------------------------------------------------
package chroma_sub_pkg;

  // mode register codes
  localparam logic [2:0] MODE_444      = 3'd0;
  localparam logic [2:0] MODE_422      = 3'd1;
  localparam logic [2:0] MODE_411      = 3'd2;
  localparam logic [2:0] MODE_420_DROP = 3'd3;
  localparam logic [2:0] MODE_420_VMEAN = 3'd4;
  localparam logic [2:0] MODE_420_FMEAN = 3'd5;

  // configuration register indexes
  localparam logic CFG_MODE       = 1'b0;
  localparam logic CFG_LINE_WIDTH = 1'b1;

  localparam int MODE_W   = 3;
  localparam int LW_W     = 12;
  localparam int SAMPLE_W = 8;
  localparam int STORE_W  = 9;
  localparam int CHROMA_W = 10;
  localparam int OUT_TDATA_W = 16;
  localparam logic [LW_W-1:0] LW_RESET = 12'd8;
  localparam logic [LW_W-1:0] LW_MIN   = 12'd8;

  // how the result of a held word is formed
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_VMEAN,
    KIND_FMEAN
  } kind_t;

endpackage

[src/chroma_subsampler.sv]
// ----------------------------------------------------------------------------
// chroma_subsampler
// 4:4:4 / 4:2:2 / 4:1:1 / 4:2:0 chroma subsampling, Q8.2 results
// ----------------------------------------------------------------------------
// path: an accepted input word goes into the held stage (p1), then into the output register on out_
// throughput: one input word per cycle; the line store read and write port
//   each serve one word per cycle, so stalls come only from out_tready
// reset: synchronous rst_n clears counters, mode (4:4:4) and width (8); the line store
//   is not cleared; the user must read it only after an even row fills it (not checked)
module chroma_subsampler #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic clk,
  input  logic rst_n,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [chroma_sub_pkg::LW_W-1:0]    cfg_data,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [chroma_sub_pkg::SAMPLE_W-1:0] in_tdata,  // [7:0] sample
  input  logic                               in_tuser,  // [0] frame_start
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [chroma_sub_pkg::OUT_TDATA_W-1:0] out_tdata, // [9:0] chroma_out, rest zero
  output logic                               out_tlast  // row_end
);
  import chroma_sub_pkg::*;

  // widths derived from the largest line
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int EW    = ((WW > LW_W) ? WW : LW_W) + 1;
  localparam int TOP   = MAX_WIDTH - (MAX_WIDTH % 4);

  // configuration state
  logic [MODE_W-1:0] mode_r;
  logic [WW-1:0]     eff_w_r, eff_w_nxt;

  // position state
  logic [CW-1:0]          col_r, col_nxt;
  logic                   odd_r, odd_nxt;
  logic signed [STORE_W-1:0] pair_sum_r, pair_sum_nxt;

  // line store: one word per pair of columns
  logic signed [STORE_W-1:0] store_mem [DEPTH];
  logic signed [STORE_W-1:0] rd_data_r;

  // held stage between store read and output register
  logic                      p1_valid_r;
  kind_t                     p1_kind_r;
  logic signed [STORE_W-1:0] p1_base_r;
  logic                      p1_rend_r;

  // output register
  logic                      out_valid_r;
  logic [CHROMA_W-1:0]       out_chroma_r;
  logic                      out_rend_r;

  logic in_acc, out_load;

  // front end decode
  logic signed [SAMPLE_W-1:0] s;
  logic [CW-1:0]  col;
  logic           odd;
  logic [WW:0]    col_x, w_x;
  logic           last_col, rend2, rend4;
  logic [2:0]     m;
  logic           emit, rend;
  kind_t          kind;
  logic signed [STORE_W-1:0] base, ps;
  logic           wr_en, rd_en;
  logic signed [STORE_W-1:0] wr_data;
  logic [IW-1:0]  idx;

  // width clamp on configuration write
  logic [EW-1:0] w_cand;

  // back end
  logic signed [CHROMA_W-1:0] sum10, res;

  assign cfg_ready = 1'b1;

  // p1 can take a new word when empty or when it moves forward this cycle
  assign out_load  = p1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    w_cand = EW'({cfg_data[LW_W-1:2], 2'b00});
    if (w_cand < EW'(LW_MIN)) begin
      w_cand = EW'(LW_MIN);
    end else if (w_cand > EW'(TOP)) begin
      w_cand = EW'(TOP);
    end
    eff_w_nxt = WW'(w_cand);
  end

  always_comb begin
    s     = signed'(in_tdata);
    col   = in_tuser ? '0 : col_r;
    odd   = in_tuser ? 1'b0 : odd_r;
    col_x = (WW+1)'(col);
    w_x   = (WW+1)'(eff_w_r);
    last_col = (col_x + (WW+1)'(1)) >= w_x;
    rend2    = (col_x + (WW+1)'(2)) >= w_x;
    rend4    = (col_x + (WW+1)'(4)) >= w_x;
    idx   = IW'(col >> 1);
    ps    = pair_sum_r + STORE_W'(s);
    m     = (mode_r > MODE_420_FMEAN) ? MODE_444 : mode_r;

    emit = 1'b0;
    rend = 1'b0;
    kind = KIND_PASS;
    base = STORE_W'(s);
    wr_en = 1'b0;
    rd_en = 1'b0;
    wr_data = STORE_W'(s);
    pair_sum_nxt = pair_sum_r;

    case (m)
      MODE_422: begin
        emit = !col[0];
        rend = rend2;
      end
      MODE_411: begin
        emit = (col[1:0] == 2'b00);
        rend = rend4;
      end
      MODE_420_DROP: begin
        emit = !odd && !col[0];
        rend = rend2;
      end
      MODE_420_VMEAN: begin
        // even row fills the store, odd row averages against it
        kind = KIND_VMEAN;
        rend = rend2;
        if (!col[0]) begin
          wr_en = !odd;
          rd_en = odd;
          emit  = odd;
        end
      end
      MODE_420_FMEAN: begin
        // horizontal pair sum first, then vertical through the store
        kind = KIND_FMEAN;
        rend = last_col;
        base = ps;
        wr_data = ps;
        if (!col[0]) begin
          pair_sum_nxt = STORE_W'(s);
        end else begin
          wr_en = !odd;
          rd_en = odd;
          emit  = odd;
        end
      end
      default: begin
        emit = 1'b1;
        rend = last_col;
      end
    endcase

    if (last_col) begin
      col_nxt = '0;
      odd_nxt = !odd;
    end else begin
      col_nxt = col + CW'(1);
      odd_nxt = odd;
    end
  end

  // line store, one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      store_mem[idx] <= wr_data;
    end
    if (in_acc && rd_en) begin
      rd_data_r <= store_mem[idx];
    end
  end

  // result formation from the held word and the store read
  always_comb begin
    sum10 = CHROMA_W'(rd_data_r) + CHROMA_W'(p1_base_r);
    case (p1_kind_r)
      KIND_VMEAN: res = {sum10[CHROMA_W-2:0], 1'b0};
      KIND_FMEAN: res = sum10;
      default:    res = {p1_base_r[SAMPLE_W-1:0], 2'b00};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_444;
      eff_w_r     <= WW'(LW_RESET);
      col_r       <= '0;
      odd_r       <= 1'b0;
      pair_sum_r  <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:       mode_r  <= cfg_data[MODE_W-1:0];
          CFG_LINE_WIDTH: eff_w_r <= eff_w_nxt;
          default: ;
        endcase
      end
      if (in_acc) begin
        col_r      <= col_nxt;
        odd_r      <= odd_nxt;
        pair_sum_r <= pair_sum_nxt;
        p1_valid_r <= emit;
      end else if (out_load) begin
        p1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_kind_r <= kind;
      p1_base_r <= base;
      p1_rend_r <= rend;
    end
    if (out_load) begin
      out_chroma_r <= res;
      out_rend_r   <= p1_rend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-CHROMA_W)'(0), out_chroma_r};
  assign out_tlast  = out_rend_r;

endmodule

[dv/chroma_subsampler_check.sv]
// ----------------------------------------------------------------------------
// chroma_subsampler_check
// watches the register, sample and result channels of the chroma subsampler,
// predicts each result word and compares it field by field
// ----------------------------------------------------------------------------
module chroma_subsampler_check #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [chroma_sub_pkg::LW_W-1:0]        cfg_data,
  input  logic                                   in_tvalid,
  input  logic                                   in_tready,
  input  logic [chroma_sub_pkg::SAMPLE_W-1:0]    in_tdata,   // [7:0] sample
  input  logic                                   in_tuser,   // [0] frame_start
  input  logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic [chroma_sub_pkg::OUT_TDATA_W-1:0] out_tdata,  // [9:0] chroma_out
  input  logic                                   out_tlast,  // row_end
  output int                                     errors,
  output int                                     pending,
  output int                                     results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import chroma_sub_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH / 2;

  typedef struct packed {
    logic signed [CHROMA_W-1:0] chroma;
    logic                       row_end;
  } chroma_word_t;

  logic [MODE_W-1:0]         mode_reg;
  logic [LW_W-1:0]           width_reg;
  int unsigned               col_pos;
  logic                      on_odd_row;
  logic signed [STORE_W-1:0] pair_acc;
  logic signed [STORE_W-1:0] top_row [STORE_DEPTH];
  chroma_word_t              expected_chroma [$];

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
  end

  // usable row length: low two bits dropped, clamped to the legal range
  function automatic int unsigned row_span();
    int unsigned w;
    int unsigned ceiling;
    w = {width_reg[LW_W-1:2], 2'b00};
    ceiling = MAX_WIDTH & ~3;
    if (w < LW_MIN) w = LW_MIN;
    if (w > ceiling) w = ceiling;
    return w;
  endfunction

  // advances the raster position and returns 1 when the sample makes a word
  function automatic bit subsample(input logic signed [SAMPLE_W-1:0] s,
                                   input logic frame_start,
                                   output chroma_word_t word);
    int unsigned       span;
    int unsigned       col;
    int unsigned       slot;
    logic              last;
    bit                emit;
    int                val;
    int                sum2;
    logic [MODE_W-1:0] m;
    emit = 1'b0;
    val = 0;
    word = '0;
    if (frame_start) begin
      col_pos = 0;
      on_odd_row = 1'b0;
    end
    span = row_span();
    col = col_pos;
    last = (col + 1 >= span);
    slot = (col >> 1) % STORE_DEPTH;
    m = (mode_reg > MODE_420_FMEAN) ? MODE_444 : mode_reg;
    case (m)
      MODE_422: if (!col[0]) begin
        emit = 1'b1;
        val = int'(s) * 4;
        word.row_end = (col + 2 >= span);
      end
      MODE_411: if (col[1:0] == 2'b00) begin
        emit = 1'b1;
        val = int'(s) * 4;
        word.row_end = (col + 4 >= span);
      end
      MODE_420_DROP: if (!on_odd_row && !col[0]) begin
        emit = 1'b1;
        val = int'(s) * 4;
        word.row_end = (col + 2 >= span);
      end
      MODE_420_VMEAN: if (!col[0]) begin
        if (!on_odd_row) begin
          top_row[slot] = STORE_W'(s);
        end else begin
          emit = 1'b1;
          val = (int'(top_row[slot]) + int'(s)) * 2;
          word.row_end = (col + 2 >= span);
        end
      end
      MODE_420_FMEAN: begin
        if (!col[0]) begin
          pair_acc = STORE_W'(s);
        end else begin
          sum2 = int'(pair_acc) + int'(s);
          if (!on_odd_row) begin
            top_row[slot] = sum2[STORE_W-1:0];
          end else begin
            emit = 1'b1;
            val = int'(top_row[slot]) + sum2;
            word.row_end = last;
          end
        end
      end
      default: begin
        emit = 1'b1;
        val = int'(s) * 4;
        word.row_end = last;
      end
    endcase
    if (last) begin
      col_pos = 0;
      on_odd_row = ~on_odd_row;
    end else begin
      col_pos = col + 1;
    end
    word.chroma = val[CHROMA_W-1:0];
    return emit;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    chroma_word_t got;
    chroma_word_t want;
    if (!rst_n) begin
      mode_reg = MODE_444;
      width_reg = LW_RESET;
      col_pos = 0;
      on_odd_row = 1'b0;
      pair_acc = '0;
      expected_chroma.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MODE) mode_reg = cfg_data[MODE_W-1:0];
        else if (cfg_index == CFG_LINE_WIDTH) width_reg = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        if (subsample(in_tdata, in_tuser, want)) expected_chroma = {expected_chroma, want};
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.chroma = out_tdata[CHROMA_W-1:0];
        got.row_end = out_tlast;
        if (expected_chroma.size() == 0) begin
          flag_mismatch($sformatf("result word %0d with nothing expected (chroma %0d)",
                                  results_seen, got.chroma));
        end else begin
          want = expected_chroma.pop_front();
          if (out_tdata !== {{(OUT_TDATA_W-CHROMA_W){1'b0}}, want.chroma})
            flag_mismatch($sformatf("word %0d chroma_out %0d (tdata %h), want %0d",
                                    results_seen, got.chroma, out_tdata, want.chroma));
          if (out_tlast !== want.row_end)
            flag_mismatch($sformatf("word %0d row_end %b, want %b",
                                    results_seen, out_tlast, want.row_end));
        end
      end
    end
    pending = expected_chroma.size();
  end

endmodule

[dv/chroma_subsampler_test.sv]
// ----------------------------------------------------------------------------
// chroma_subsampler_test
// drives the chroma subsampler through every mode code and a spread of line
// widths, first a short fixed sequence, then random frames with idle gaps on
// both streams; a checker beside the block predicts and compares every word
// ----------------------------------------------------------------------------
module chroma_subsampler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import chroma_sub_pkg::*;

  localparam int          MAX_WIDTH     = 2048;
  localparam int          SETTLE        = 4;    // held stage and output register plus margin
  localparam int          IDLE_PCT      = 29;
  localparam int          RANDOM_PHASES = 15;
  localparam int          WIDE_PHASE    = 6;    // the phase that always runs at full width
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7; // unused code, acts as 4:4:4

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = CFG_MODE;
  logic [LW_W-1:0]        cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata = '0;    // [7:0] sample
  logic                   in_tuser = 1'b0;  // [0] frame_start
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [9:0] chroma_out, rest zero
  logic                   out_tlast;        // row_end

  int check_errors;
  int pending;
  int results_seen;

  // stimulus-side view of the raster position, used only to keep odd-row
  // reads of the line store on entries that an even row already filled
  logic [MODE_W-1:0] mode_now = MODE_444;
  logic [LW_W-1:0]   lw_now = LW_RESET;
  int unsigned       col_now = 0;
  logic              odd_now = 1'b0;
  bit                filled [MAX_WIDTH/2];

  bit calm = 1'b0;      // no idling on either side while set
  int words_sent = 0;
  int settings_made = 0;

  chroma_subsampler #(.MAX_WIDTH(MAX_WIDTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  chroma_subsampler_check #(.MAX_WIDTH(MAX_WIDTH)) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .errors       (check_errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("timeout with %0d result words still expected", pending);
    $display("[chroma_subsampler] ERROR");
    $finish;
  end

  // result side: stalls at random, none while calm
  initial begin
    forever begin
      @(posedge clk);
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic int unsigned span_of(input logic [LW_W-1:0] lw);
    int unsigned w;
    w = {lw[LW_W-1:2], 2'b00};
    if (w < LW_MIN) w = LW_MIN;
    if (w > (MAX_WIDTH & ~3)) w = MAX_WIDTH & ~3;
    return w;
  endfunction

  // hold off until every expected word is out, then let no-result samples
  // still in the pipe drain
  task automatic drain();
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // both registers, back to back on the write channel, only while idle
  task automatic load_settings(input logic [MODE_W-1:0] m, input logic [LW_W-1:0] lw);
    logic [LW_W-MODE_W-1:0] pad;
    drain();
    // upper bits of a mode write are don't-care, so junk goes there sometimes
    pad = ($urandom_range(3) == 0) ? (LW_W-MODE_W)'($urandom) : '0;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= {pad, m};
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data  <= lw;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    mode_now = m;
    lw_now = lw;
    settings_made++;
  endtask

  // one sample word; frame_start gets forced on when the word would read a
  // line store entry that no even row has written yet
  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic fs_in);
    logic              fs;
    logic [MODE_W-1:0] m;
    int unsigned       span;
    bit                reads_store;
    m = (mode_now > MODE_420_FMEAN) ? MODE_444 : mode_now;
    span = span_of(lw_now);
    fs = fs_in;
    reads_store = odd_now && ((m == MODE_420_VMEAN && !col_now[0]) ||
                              (m == MODE_420_FMEAN && col_now[0]));
    if (reads_store && !filled[col_now >> 1]) fs = 1'b1;
    if (fs) begin
      col_now = 0;
      odd_now = 1'b0;
    end
    if (!odd_now && ((m == MODE_420_VMEAN && !col_now[0]) ||
                     (m == MODE_420_FMEAN && col_now[0])))
      filled[col_now >> 1] = 1'b1;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= fs;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    words_sent++;
    // a shrunken width makes a column past the end wrap at once
    if (col_now + 1 >= span) begin
      col_now = 0;
      odd_now = ~odd_now;
    end else begin
      col_now++;
    end
  endtask

  initial begin : stimulus
    logic [MODE_W-1:0]   seg_mode [8];
    int                  seg_len [8];
    logic [MODE_W-1:0]   m;
    logic [LW_W-1:0]     lw;
    logic [SAMPLE_W-1:0] s;
    logic                fs;
    bit                  fresh;
    int                  n;
    int                  pick;

    // fixed opening at width 8, one frame, mode switched between segments:
    // row 0 drop / 4:2:2 / 4:1:1, row 1 drop (silent) / spare code / 4:4:4,
    // row 2 fills the store in vertical mean, row 3 reads it back in
    // vertical mean then full mean
    seg_mode = '{MODE_420_DROP, MODE_422, MODE_411, MODE_420_DROP,
                 MODE_SPARE_HI, MODE_444, MODE_420_VMEAN, MODE_420_FMEAN};
    seg_len  = '{2, 2, 4, 2, 2, 4, 12, 4};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int g = 0; g < 8; g++) begin
      load_settings(seg_mode[g], LW_MIN);
      for (int k = 0; k < seg_len[g]; k++) begin
        fs = (g == 0 && k == 0);
        // column pairs alternate between the two sample extremes, so the
        // means hit both ends of the output range
        s = (((fs ? 0 : col_now) & 2) != 0) ? 8'h80 : 8'h7F;
        send_word(s, fs);
      end
      in_tvalid <= 1'b0;
    end

    // random frames; the first eight phases walk every mode code, later ones
    // lean toward the averaging modes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == 9 || p == 10);
      if (p < 8) m = MODE_W'(p);
      else if ($urandom_range(1) == 1) m = $urandom_range(1) ? MODE_420_VMEAN : MODE_420_FMEAN;
      else m = MODE_W'($urandom_range(7));
      pick = $urandom_range(99);
      if (p == WIDE_PHASE) lw = (pick < 50) ? {LW_W{1'b1}} : LW_W'(MAX_WIDTH);
      else if (pick < 70) lw = LW_W'(4 * $urandom_range(8, 2));
      else if (pick < 80) lw = LW_W'($urandom_range(4095));
      else if (pick < 88) lw = LW_W'($urandom_range(LW_MIN - 1));
      else lw = LW_W'(4 * $urandom_range(8, 2) + $urandom_range(3, 1));
      load_settings(m, lw);

      // most phases open a fresh frame, the rest carry the old position over
      // so the new mode or width lands mid-row
      fresh = ($urandom_range(3) != 0);
      n = (p == WIDE_PHASE) ? MAX_WIDTH / 2 + 52 : $urandom_range(64, 40);
      for (int k = 0; k < n; k++) begin
        fs = (k == 0 && fresh) || ($urandom_range(99) < 2);
        pick = $urandom_range(9);
        if (pick == 0) s = 8'h7F;
        else if (pick == 1) s = 8'h80;
        else s = SAMPLE_W'($urandom_range(255));
        if (p == 3 && k == n / 2) begin
          // sender waits mid-frame until the block has nothing left to give
          in_tvalid <= 1'b0;
          drain();
        end
        send_word(s, fs);
      end
      in_tvalid <= 1'b0;
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("%0d sample words over %0d register settings: all eight mode codes, widths",
             words_sent, settings_made);
    $display("from below the minimum to the full 2048, restarts and mode changes mid-row, %0d results",
             results_seen);
    if (check_errors == 0) begin
      $display("[chroma_subsampler] OK");
    end else begin
      $display("%0d mismatches", check_errors);
      $display("[chroma_subsampler] ERROR");
    end
    $finish;
  end

endmodule
